[src/mhe_pkg.sv]
// shared constants, status codes and memory request type for the heap extract block
package mhe_pkg;

   // storage geometry
   localparam int DEPTH       = 1024;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int CHILD_W     = ADDR_W + 2;
   localparam int KEY_W       = 64;
   localparam int COUNT_OUT_W = 11;
   localparam int STATUS_W    = 2;

   // request modes
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // one write port and two read ports into the key store
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } ram_req_type;

endpackage

[src/mhe_if.sv]
// request and result channel interfaces of the heap extract block
interface mhe_req_if;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [mhe_pkg::KEY_W-1:0] key_in;

   modport source (output valid, output mode, output key_in, input ready);
   modport sink   (input valid, input mode, input key_in, output ready);
endinterface

interface mhe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mhe_pkg::KEY_W-1:0]       popped_key;
   logic [mhe_pkg::STATUS_W-1:0]    status;
   logic [mhe_pkg::COUNT_OUT_W-1:0] count_after;

   modport source (output valid, output popped_key, output status, output count_after,
                   input ready);
   modport sink   (input valid, input popped_key, input status, input count_after,
                   output ready);
endinterface

[src/mhe_ram.sv]
// key store: one write port, two registered read ports
module mhe_ram (
   input  logic                         clock,
   input  mhe_pkg::ram_req_type         ram_req,
   output logic [mhe_pkg::KEY_W-1:0]    rd_data_a,
   output logic [mhe_pkg::KEY_W-1:0]    rd_data_b
);

   logic [mhe_pkg::KEY_W-1:0] mem [mhe_pkg::DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read ports, registered
   always_ff @(posedge clock) begin
      rd_data_a <= mem[ram_req.rd_addr_a];
      rd_data_b <= mem[ram_req.rd_addr_b];
   end

endmodule

[src/min_heap_extract_u64.sv]
// binary min-heap of 64-bit keys with append and extract-min, store in one memory
//
//   channel   role     payload
//   req_bus   sink     mode, key_in
//   rsp_bus   source   popped_key, status, count_after
//
// an append or a failed request goes through the finish state to the output register
// a pop reads the root and the last leaf, then sifts down one level per step (one child
// read pair, compare and write-back per level), at most log2(DEPTH) levels
// requests are taken only while the sequencer is idle; a result waits in the output
// register, and a finished item holds until that register is free
// synchronous reset empties the heap; store contents need no clearing
module min_heap_extract_u64 (
   input  logic    clock,
   input  logic    reset,
   mhe_req_if.sink   req_bus,
   mhe_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_SIFT,
      ST_FINISH
   } state_type;

   state_type                              state_ff;
   logic [mhe_pkg::CNT_W-1:0]             count_ff;
   logic [mhe_pkg::ADDR_W-1:0]            pos_ff;
   logic [mhe_pkg::KEY_W-1:0]             key_ff;
   logic [mhe_pkg::KEY_W-1:0]             popped_ff;
   logic [mhe_pkg::STATUS_W-1:0]          status_ff;
   logic                                  rsp_valid_ff;
   logic [mhe_pkg::KEY_W-1:0]             rsp_key_ff;
   logic [mhe_pkg::STATUS_W-1:0]          rsp_status_ff;
   logic [mhe_pkg::COUNT_OUT_W-1:0]       rsp_count_ff;

   mhe_pkg::ram_req_type                  ram_req;
   logic [mhe_pkg::KEY_W-1:0]             rd_data_a;
   logic [mhe_pkg::KEY_W-1:0]             rd_data_b;

   logic                                  req_take;
   logic                                  out_free;
   logic                                  store_full;
   logic [mhe_pkg::CNT_W-1:0]             count_dec;
   logic [mhe_pkg::CHILD_W-1:0]           left_idx;
   logic [mhe_pkg::CHILD_W-1:0]           right_idx;
   logic                                  left_ok;
   logic                                  right_ok;
   logic                                  left_lt;
   logic                                  right_lt;
   logic                                  right_lt_left;
   logic                                  pick_left;
   logic                                  pick_right;
   logic [mhe_pkg::ADDR_W-1:0]            best_pos;
   logic [mhe_pkg::KEY_W-1:0]             best_key;
   logic [mhe_pkg::CHILD_W-1:0]           next_left;

   mhe_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // handshake
   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign req_take            = req_bus.valid && req_bus.ready;
   assign out_free            = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.popped_key  = rsp_key_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.count_after = rsp_count_ff;

   assign store_full = (count_ff >= mhe_pkg::CNT_W'(mhe_pkg::DEPTH));
   assign count_dec  = count_ff - mhe_pkg::CNT_W'(1);

   // child selection at the current sift position, left wins on a tie
   assign left_idx      = {1'b0, pos_ff, 1'b1};
   assign right_idx     = left_idx + mhe_pkg::CHILD_W'(1);
   assign left_ok       = (left_idx < mhe_pkg::CHILD_W'(count_ff));
   assign right_ok      = (right_idx < mhe_pkg::CHILD_W'(count_ff));
   assign left_lt       = (rd_data_a < key_ff);
   assign right_lt      = (rd_data_b < key_ff);
   assign right_lt_left = (rd_data_b < rd_data_a);

   always_comb begin
      pick_left  = 1'b0;
      pick_right = 1'b0;
      if (left_ok && left_lt) begin
         if (right_ok && right_lt_left) begin
            pick_right = 1'b1;
         end else begin
            pick_left = 1'b1;
         end
      end else if (right_ok && right_lt) begin
         pick_right = 1'b1;
      end
   end

   assign best_pos  = pick_right ? right_idx[mhe_pkg::ADDR_W-1:0]
                                 : left_idx[mhe_pkg::ADDR_W-1:0];
   assign best_key  = pick_right ? rd_data_b : rd_data_a;
   assign next_left = {1'b0, best_pos, 1'b1};

   // memory port control
   always_comb begin
      ram_req.wr_en     = 1'b0;
      ram_req.wr_addr   = count_ff[mhe_pkg::ADDR_W-1:0];
      ram_req.wr_data   = req_bus.key_in;
      ram_req.rd_addr_a = '0;
      ram_req.rd_addr_b = count_dec[mhe_pkg::ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            ram_req.wr_en = req_take && (req_bus.mode == mhe_pkg::MODE_APPEND) && !store_full;
         end
         ST_POP_RD: begin
            ram_req.rd_addr_a = mhe_pkg::ADDR_W'(1);
            ram_req.rd_addr_b = mhe_pkg::ADDR_W'(2);
         end
         ST_SIFT: begin
            ram_req.wr_en     = 1'b1;
            ram_req.wr_addr   = pos_ff;
            ram_req.wr_data   = (pick_left || pick_right) ? best_key : key_ff;
            ram_req.rd_addr_a = next_left[mhe_pkg::ADDR_W-1:0];
            ram_req.rd_addr_b = next_left[mhe_pkg::ADDR_W-1:0] + mhe_pkg::ADDR_W'(1);
         end
         default: begin
            ram_req.wr_en = 1'b0;
         end
      endcase
   end

   // sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: load a finished item, drop a taken one
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  popped_ff <= '0;
                  if (req_bus.mode == mhe_pkg::MODE_APPEND) begin
                     state_ff <= ST_FINISH;
                     if (store_full) begin
                        status_ff <= mhe_pkg::STATUS_FULL;
                     end else begin
                        status_ff <= mhe_pkg::STATUS_OK;
                        count_ff  <= count_ff + mhe_pkg::CNT_W'(1);
                     end
                  end else if (count_ff == '0) begin
                     state_ff  <= ST_FINISH;
                     status_ff <= mhe_pkg::STATUS_EMPTY;
                  end else begin
                     state_ff  <= ST_POP_RD;
                     status_ff <= mhe_pkg::STATUS_OK;
                  end
               end
            end
            ST_POP_RD: begin
               popped_ff <= rd_data_a;
               key_ff    <= rd_data_b;
               pos_ff    <= '0;
               count_ff  <= count_dec;
               state_ff  <= (count_dec == '0) ? ST_FINISH : ST_SIFT;
            end
            ST_SIFT: begin
               if (pick_left || pick_right) begin
                  pos_ff <= best_pos;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_key_ff    <= popped_ff;
                  rsp_status_ff <= status_ff;
                  rsp_count_ff  <= mhe_pkg::COUNT_OUT_W'(count_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // live count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mhe_pkg::CNT_W'(mhe_pkg::DEPTH))
      else $error("live count beyond store depth");

   // sift position always refers to a live entry
   a_sift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIFT) |-> (mhe_pkg::CNT_W'(pos_ff) < count_ff))
      else $error("sift position outside live keys");

   // a pop removes exactly one key
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_RD) |=> (count_ff == $past(count_ff) - mhe_pkg::CNT_W'(1)))
      else $error("pop did not decrement count");

   // the store is written only by an append or a sift step
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> ((state_ff == ST_SIFT) || (state_ff == ST_IDLE && req_take)))
      else $error("unexpected store write");

endmodule

[verif/tb_top.sv]
// self-checking testbench for the min-heap extract block: shadow heap predictor, random traffic
module tb_top;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 4;
   localparam int MIX_ITEMS    = 360;
   localparam int DEEP_FILL    = 160;
   localparam int DEEP_DRAIN   = 160;
   localparam int CALM_TAIL    = 150;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 600000;

   // two copies of the heap: one steers stimulus, one predicts results
   localparam int GEN_VIEW = 0;
   localparam int CHK_VIEW = 1;

   typedef struct packed {
      logic                      mode;
      logic [mhe_pkg::KEY_W-1:0] key_in;
   } heap_request_type;

   typedef struct packed {
      logic [mhe_pkg::KEY_W-1:0]       popped_key;
      logic [mhe_pkg::STATUS_W-1:0]    status;
      logic [mhe_pkg::COUNT_OUT_W-1:0] count_after;
   } heap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mhe_req_if req_bus ();
   mhe_rsp_if rsp_bus ();

   min_heap_extract_u64 DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [mhe_pkg::KEY_W-1:0] heap_copy [2][mhe_pkg::DEPTH];
   int                        heap_len  [2];

   heap_request_type pending_requests [$];
   heap_result_type  expected_results [$];
   heap_request_type next_request;

   logic calm = 1'b0;
   int   accepted_requests = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;

   int error_count = 0;
   int results_checked = 0;
   int append_count = 0;
   int pop_count = 0;
   int empty_pops = 0;
   int full_appends = 0;
   int peak_size = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // apply one request to a heap copy and return the result it gives
   function automatic heap_result_type apply_heap_request(input int view,
                                                          input heap_request_type rq);
      heap_result_type           res;
      int                        n, pos, lc, rc, best;
      bit                        settled;
      logic [mhe_pkg::KEY_W-1:0] tmp;
      res = '0;
      res.status = mhe_pkg::STATUS_OK;
      n = heap_len[view];
      if (rq.mode == mhe_pkg::MODE_APPEND) begin
         if (n >= mhe_pkg::DEPTH) begin
            res.status = mhe_pkg::STATUS_FULL;
         end else begin
            heap_copy[view][n] = rq.key_in;
            n++;
         end
      end else if (n == 0) begin
         res.status = mhe_pkg::STATUS_EMPTY;
      end else begin
         res.popped_key = heap_copy[view][0];
         n--;
         if (n > 0) begin
            // last leaf to the root, then sift down towards the smaller child
            heap_copy[view][0] = heap_copy[view][n];
            pos = 0;
            settled = 1'b0;
            while (!settled) begin
               lc = 2 * pos + 1;
               rc = lc + 1;
               best = pos;
               if (lc < n && heap_copy[view][lc] < heap_copy[view][best]) best = lc;
               if (rc < n && heap_copy[view][rc] < heap_copy[view][best]) best = rc;
               if (best == pos) begin
                  settled = 1'b1;
               end else begin
                  tmp = heap_copy[view][pos];
                  heap_copy[view][pos] = heap_copy[view][best];
                  heap_copy[view][best] = tmp;
                  pos = best;
               end
            end
         end
      end
      heap_len[view] = n;
      res.count_after = n[mhe_pkg::COUNT_OUT_W-1:0];
      return res;
   endfunction

   // a key that keeps heap order under the next free slot, now and then a stray one
   function automatic logic [mhe_pkg::KEY_W-1:0] next_heap_key();
      logic [mhe_pkg::KEY_W-1:0] floor_key, step, key;
      int                        n;
      n = heap_len[GEN_VIEW];
      step = {$urandom, $urandom} >> $urandom_range(4, 63);
      if ($urandom_range(0, 39) == 0) begin
         key = {$urandom, $urandom};
      end else if (n == 0) begin
         key = {$urandom, $urandom} >> $urandom_range(0, 63);
      end else begin
         floor_key = heap_copy[GEN_VIEW][(n - 1) / 2];
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               key = floor_key;
            end
            3: begin
               key = '1;
            end
            default: begin
               key = (step > ~floor_key) ? '1 : floor_key + step;
            end
         endcase
      end
      return key;
   endfunction

   task automatic enqueue_heap_request(input logic mode,
                                       input logic [mhe_pkg::KEY_W-1:0] key);
      heap_request_type rq;
      rq.mode = mode;
      rq.key_in = key;
      void'(apply_heap_request(GEN_VIEW, rq));
      pending_requests.push_back(rq);
   endtask

   task automatic check_field(input string what, input logic [mhe_pkg::KEY_W-1:0] want,
                              input logic [mhe_pkg::KEY_W-1:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %0h actual %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   // request driver: random gaps, holds a request until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(apply_heap_request(CHK_VIEW,
               heap_request_type'({req_bus.mode, req_bus.key_in})));
            accepted_requests <= accepted_requests + 1;
            if (req_bus.mode == mhe_pkg::MODE_APPEND) append_count++;
            else pop_count++;
         end
         calm <= (pending_requests.size() < CALM_TAIL);
         if (req_bus.valid && !req_bus.ready) begin
            // request still on offer
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() != 0 && !calm && $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(0, 17);
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_request = pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.mode <= next_request.mode;
            req_bus.key_in <= next_request.key_in;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus one long hold to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && accepted_requests >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // result monitor: compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result: popped_key %0h status %0d count_after %0d",
                     $time, rsp_bus.popped_key, rsp_bus.status, rsp_bus.count_after);
            error_count++;
         end else begin
            check_field("popped_key", expected_results[0].popped_key, rsp_bus.popped_key);
            check_field("status", 64'(expected_results[0].status), 64'(rsp_bus.status));
            check_field("count_after", 64'(expected_results[0].count_after),
                        64'(rsp_bus.count_after));
            if (expected_results[0].status == mhe_pkg::STATUS_EMPTY) empty_pops++;
            if (expected_results[0].status == mhe_pkg::STATUS_FULL) full_appends++;
            if (int'(rsp_bus.count_after) > peak_size) peak_size = int'(rsp_bus.count_after);
            void'(expected_results.pop_front());
            results_checked++;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int  i, phase_left;
      bit  grow;
      req_bus.valid = 1'b0;
      req_bus.mode = mhe_pkg::MODE_APPEND;
      req_bus.key_in = '0;
      rsp_bus.ready = 1'b0;
      heap_len[GEN_VIEW] = 0;
      heap_len[CHK_VIEW] = 0;

      // directed: empty pops, pops down to one and zero keys, equal children, key extremes
      enqueue_heap_request(mhe_pkg::MODE_POP, '1);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, '0);
      enqueue_heap_request(mhe_pkg::MODE_POP, '0);
      enqueue_heap_request(mhe_pkg::MODE_POP, '0);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, 64'd1);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, 64'd3);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, 64'd3);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, 64'd9);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, '1);
      enqueue_heap_request(mhe_pkg::MODE_POP, '1);
      enqueue_heap_request(mhe_pkg::MODE_POP, '0);
      enqueue_heap_request(mhe_pkg::MODE_POP, '1);
      enqueue_heap_request(mhe_pkg::MODE_POP, '0);
      enqueue_heap_request(mhe_pkg::MODE_POP, '1);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, 64'h8000_0000_0000_0000);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, '1);
      enqueue_heap_request(mhe_pkg::MODE_APPEND, 64'h8000_0000_0000_0001);
      enqueue_heap_request(mhe_pkg::MODE_POP, '0);
      enqueue_heap_request(mhe_pkg::MODE_POP, '1);
      enqueue_heap_request(mhe_pkg::MODE_POP, '0);
      enqueue_heap_request(mhe_pkg::MODE_POP, '1);

      // random: alternating grow and drain spells keep the heap size moving
      grow = 1'b0;
      phase_left = 0;
      for (i = 0; i < MIX_ITEMS; i++) begin
         if (phase_left == 0) begin
            grow = !grow;
            phase_left = $urandom_range(15, 60);
         end
         phase_left--;
         if ($urandom_range(0, 9) < (grow ? 8 : 2))
            enqueue_heap_request(mhe_pkg::MODE_APPEND, next_heap_key());
         else
            enqueue_heap_request(mhe_pkg::MODE_POP, {$urandom, $urandom});
      end

      // grow a deep heap, then mostly pop through long sifts with occasional appends
      for (i = 0; i < DEEP_FILL; i++)
         enqueue_heap_request(mhe_pkg::MODE_APPEND, next_heap_key());
      for (i = 0; i < DEEP_DRAIN; i++) begin
         if ($urandom_range(0, 9) == 0)
            enqueue_heap_request(mhe_pkg::MODE_APPEND, next_heap_key());
         else
            enqueue_heap_request(mhe_pkg::MODE_POP, {$urandom, $urandom});
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_bus.valid !== 1'b0) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests (%0d appends, %0d pops), %0d results checked",
               append_count + pop_count, append_count, pop_count, results_checked);
      $display("run: %0d pops on an empty heap, %0d appends to a full store, peak size %0d",
               empty_pops, full_appends, peak_size);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
src/mhe_pkg.sv
src/mhe_if.sv
src/mhe_ram.sv
src/min_heap_extract_u64.sv
verif/tb_top.sv
